// ===== src/invs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// invs_pkg
// Shared widths, constants and register codes of the normal-view shader.
// ----------------------------------------------------------------------------
package invs_pkg;

    localparam int COMPONENT_BITS_DEF = 16;

    // Q1.15 unit component with room for +1.0
    localparam int UNIT_BITS = 17;
    // quotient bits of c * 2^15 / length
    localparam int QUOT_BITS = 16;
    // weighted normal sum after the divide by 256
    localparam int SUM_BITS  = 26;

    localparam int ADDR_BITS = 4;

    localparam logic [17:0] LEVEL_BASE = 18'd98304;
    localparam logic [15:0] LEVEL_MAX  = 16'd32768;
    // ceil(2^16 / 5), exact for the quotients that occur here
    localparam logic [13:0] RECIP_FIVE = 14'd13108;

    typedef enum logic [1:0] {
        REG_CAMERA_X = 2'd0,
        REG_CAMERA_Y = 2'd1,
        REG_CAMERA_Z = 2'd2
    } reg_index_t;

endpackage

// ===== src/invs_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// invs_norm
// Pipelined vector normalizer: squares, sum, bit-per-stage square root and
// bit-per-stage division, giving signed Q1.15 components.
// ----------------------------------------------------------------------------
module invs_norm
    import invs_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                          aclk,
    input  logic                          advance,
    input  logic [2:0][W-1:0]             comp_in,
    output logic [2:0][UNIT_BITS-1:0]     unit_out
);

    localparam int SUM_W  = 2 * W + 2;
    localparam int ROOT_W = W;
    localparam int DIV_W  = W + QUOT_BITS - 1;

    logic signed [2*W-1:0]   sq_next [3];
    logic [2:0][2*W-1:0]     sq_reg;
    logic [2:0][W-1:0]       c1_reg;
    logic [2:0][W-1:0]       c2_reg;
    logic [SUM_W-1:0]        sum_reg;

    always_comb begin
        for (int n = 0; n < 3; n++) begin
            sq_next[n] = $signed(comp_in[n]) * $signed(comp_in[n]);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int n = 0; n < 3; n++) begin
                sq_reg[n] <= sq_next[n];
            end
            c1_reg  <= comp_in;
            sum_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            c2_reg  <= c1_reg;
        end
    end

    // square root, one result bit per stage, most significant first
    logic [SUM_W-1:0]   rem_reg  [W];
    logic [ROOT_W-1:0]  root_reg [W];
    logic [2:0][W-1:0]  sc_reg   [W];

    for (genvar k = 0; k < W; k++) begin : g_sqrt
        localparam int I = W - 1 - k;
        logic [SUM_W-1:0]  rem_in;
        logic [SUM_W-1:0]  trial;
        logic [ROOT_W-1:0] root_in;
        logic [2:0][W-1:0] c_in;

        if (k == 0) begin : g_first
            assign rem_in  = sum_reg;
            assign root_in = '0;
            assign c_in    = c2_reg;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign c_in    = sc_reg[k-1];
        end

        // (root + 2^I)^2 - root^2
        assign trial = (SUM_W'(root_in) << (I + 1)) + (SUM_W'(1) << (2 * I));

        always_ff @(posedge aclk) begin
            if (advance) begin
                if (rem_in >= trial) begin
                    rem_reg[k]  <= rem_in - trial;
                    root_reg[k] <= root_in | (ROOT_W'(1) << I);
                end else begin
                    rem_reg[k]  <= rem_in;
                    root_reg[k] <= root_in;
                end
                sc_reg[k] <= c_in;
            end
        end
    end

    // restoring division of |c| * 2^15 by the length
    logic [W-1:0]            mag [3];
    logic [2:0][DIV_W-1:0]   p0;
    logic [2:0]              neg0;

    always_comb begin
        for (int n = 0; n < 3; n++) begin
            neg0[n] = sc_reg[W-1][n][W-1];
            mag[n]  = neg0[n] ? (~sc_reg[W-1][n] + W'(1)) : sc_reg[W-1][n];
            p0[n]   = DIV_W'(mag[n]) << (QUOT_BITS - 1);
        end
    end

    logic [2:0][DIV_W-1:0]     p_reg   [QUOT_BITS];
    logic [2:0][QUOT_BITS-1:0] q_reg   [QUOT_BITS];
    logic [ROOT_W-1:0]         len_reg [QUOT_BITS];
    logic [2:0]                dn_reg  [QUOT_BITS];

    for (genvar m = 0; m < QUOT_BITS; m++) begin : g_div
        localparam int J = QUOT_BITS - 1 - m;
        logic [2:0][DIV_W-1:0]     p_in;
        logic [2:0][QUOT_BITS-1:0] q_in;
        logic [ROOT_W-1:0]         len_in;
        logic [2:0]                dn_in;
        logic [DIV_W-1:0]          dsub;

        if (m == 0) begin : g_first
            assign p_in   = p0;
            assign q_in   = '0;
            assign len_in = root_reg[W-1];
            assign dn_in  = neg0;
        end else begin : g_rest
            assign p_in   = p_reg[m-1];
            assign q_in   = q_reg[m-1];
            assign len_in = len_reg[m-1];
            assign dn_in  = dn_reg[m-1];
        end

        assign dsub = DIV_W'(len_in) << J;

        always_ff @(posedge aclk) begin
            if (advance) begin
                for (int n = 0; n < 3; n++) begin
                    if (p_in[n] >= dsub) begin
                        p_reg[m][n] <= p_in[n] - dsub;
                        q_reg[m][n] <= q_in[n] | (QUOT_BITS'(1) << J);
                    end else begin
                        p_reg[m][n] <= p_in[n];
                        q_reg[m][n] <= q_in[n];
                    end
                end
                len_reg[m] <= len_in;
                dn_reg[m]  <= dn_in;
            end
        end
    end

    logic [2:0][UNIT_BITS-1:0] unit_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int n = 0; n < 3; n++) begin
                // zero length gives the zero vector
                if (len_reg[QUOT_BITS-1] == '0) begin
                    unit_reg[n] <= '0;
                end else if (dn_reg[QUOT_BITS-1][n]) begin
                    unit_reg[n] <= ~UNIT_BITS'(q_reg[QUOT_BITS-1][n]) + UNIT_BITS'(1);
                end else begin
                    unit_reg[n] <= UNIT_BITS'(q_reg[QUOT_BITS-1][n]);
                end
            end
        end
    end

    assign unit_out = unit_reg;

endmodule

// ===== src/interpolated_normal_view_shading.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interpolated_normal_view_shading
// Per-pixel diffuse shading from interpolated vertex normals and the view ray.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one pixel word per handshake: three vertex
//   normals, the surface point, three barycentric weights and a color. The
//   output stream returns the shaded color and the light level, one word per
//   input word, in order. The camera position is set over the APB port;
//   the user must write it only while the stream is empty; the block does not enforce this.
//   Throughput is one word per cycle while the receiver does not stall.
//   The pipeline depth is set by the two normalizer chains in series:
//   a square root stage per result bit and a division stage per quotient
//   bit, in series.
//   Reset clears the valid bits and the camera registers to zero.
//   When the receiver stalls, the whole pipeline holds and tready drops
//   until the output word is taken.
// ----------------------------------------------------------------------------
module interpolated_normal_view_shading
    import invs_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // normal_first, normal_second, normal_third, surface_point (48 each),
    // weight_first, weight_second, weight_third (16 each), color_in (24)
    input  logic [263:0]         s_axis_tdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // color_out (24), light_level (16)
    output logic [39:0]          m_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int CB  = COMPONENT_BITS;
    localparam int SW  = SUM_BITS;
    localparam int L1  = CB + QUOT_BITS + 3;
    localparam int L2  = SW + QUOT_BITS + 3;
    localparam int LAT = L1 + L2 + 6;
    localparam int PW  = 2 * UNIT_BITS;

    logic advance;
    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    // ------------------------------------------------------------------
    // camera registers
    // ------------------------------------------------------------------
    logic [15:0] cam_reg [3];
    reg_index_t  cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < 3; n++) begin
                cam_reg[n] <= '0;
            end
        end else if (psel && penable && pwrite && pready) begin
            case (cfg_index)
                REG_CAMERA_X: cam_reg[0] <= pwdata[15:0];
                REG_CAMERA_Y: cam_reg[1] <= pwdata[15:0];
                REG_CAMERA_Z: cam_reg[2] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_CAMERA_X: prdata = {16'd0, cam_reg[0]};
            REG_CAMERA_Y: prdata = {16'd0, cam_reg[1]};
            REG_CAMERA_Z: prdata = {16'd0, cam_reg[2]};
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // unpack; components past the 48-bit field read as zero
    // ------------------------------------------------------------------
    logic [47:0]        word [4];
    logic [2:0][CB-1:0] vec  [4];

    for (genvar v = 0; v < 4; v++) begin : g_unpack
        logic [3*CB+47:0] wide;
        assign word[v] = s_axis_tdata[48*v +: 48];
        assign wide    = {{(3*CB){1'b0}}, word[v]};
        assign vec[v]  = wide[3*CB-1:0];
    end

    logic [2:0][SW-1:0] ray_in;

    always_comb begin
        for (int n = 0; n < 3; n++) begin
            ray_in[n] = SW'($signed(cam_reg[n])) - SW'($signed(vec[3][n]));
        end
    end

    // ------------------------------------------------------------------
    // side data delay lines
    // ------------------------------------------------------------------
    logic [2:0][15:0]   wt_dly  [L1];
    logic [2:0][SW-1:0] ray_dly [L1+2];
    logic [23:0]        col_dly [L1+L2+4];

    always_ff @(posedge aclk) begin
        if (advance) begin
            wt_dly[0]  <= s_axis_tdata[239:192];
            ray_dly[0] <= ray_in;
            col_dly[0] <= s_axis_tdata[263:240];
            for (int i = 1; i < L1; i++) begin
                wt_dly[i] <= wt_dly[i-1];
            end
            for (int i = 1; i < L1 + 2; i++) begin
                ray_dly[i] <= ray_dly[i-1];
            end
            for (int i = 1; i < L1 + L2 + 4; i++) begin
                col_dly[i] <= col_dly[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // vertex normals
    // ------------------------------------------------------------------
    logic [2:0][UNIT_BITS-1:0] nu [3];

    for (genvar v = 0; v < 3; v++) begin : g_vnorm
        invs_norm #(
            .W (CB)
        ) u_norm (
            .aclk     (aclk),
            .advance  (advance),
            .comp_in  (vec[v]),
            .unit_out (nu[v])
        );
    end

    // weighted sum, then divide by 256 toward zero
    logic signed [PW-1:0] wp_next [3][3];
    logic signed [PW-1:0] wp_reg  [3][3];
    logic signed [35:0]   ws      [3];
    logic signed [35:0]   wadj    [3];
    logic signed [35:0]   wsh     [3];
    logic [2:0][SW-1:0]   sum_next;
    logic [2:0][SW-1:0]   sum_reg;

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            for (int n = 0; n < 3; n++) begin
                wp_next[v][n] = $signed(nu[v][n]) * $signed({1'b0, wt_dly[L1-1][v]});
            end
        end
        for (int n = 0; n < 3; n++) begin
            ws[n]       = 36'(wp_reg[0][n]) + 36'(wp_reg[1][n]) + 36'(wp_reg[2][n]);
            wadj[n]     = ws[n] + ((ws[n] < 0) ? 36'sd255 : 36'sd0);
            wsh[n]      = wadj[n] >>> 8;
            sum_next[n] = wsh[n][SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            wp_reg  <= wp_next;
            sum_reg <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // shading normal and view ray
    // ------------------------------------------------------------------
    logic [2:0][UNIT_BITS-1:0] vn;
    logic [2:0][UNIT_BITS-1:0] rn;

    invs_norm #(
        .W (SW)
    ) u_norm_sum (
        .aclk     (aclk),
        .advance  (advance),
        .comp_in  (sum_reg),
        .unit_out (vn)
    );

    invs_norm #(
        .W (SW)
    ) u_norm_ray (
        .aclk     (aclk),
        .advance  (advance),
        .comp_in  (ray_dly[L1+1]),
        .unit_out (rn)
    );

    // ------------------------------------------------------------------
    // dot product and level
    // ------------------------------------------------------------------
    logic signed [PW-1:0] dp_next [3];
    logic signed [PW-1:0] dp_reg  [3];
    logic signed [35:0]   dot;
    logic signed [35:0]   neg;
    logic signed [35:0]   nsh;
    logic [15:0]          level_next;
    logic [15:0]          level_reg;

    always_comb begin
        for (int n = 0; n < 3; n++) begin
            dp_next[n] = $signed(rn[n]) * $signed(vn[n]);
        end
        dot = 36'(dp_reg[0]) + 36'(dp_reg[1]) + 36'(dp_reg[2]);
        neg = -dot;
        nsh = neg >>> 15;
        if (neg <= 0) begin
            level_next = '0;
        end else if (nsh > 36'sd32768) begin
            level_next = LEVEL_MAX;
        end else begin
            level_next = nsh[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            dp_reg    <= dp_next;
            level_reg <= level_next;
        end
    end

    // ------------------------------------------------------------------
    // color scale: ch * (98304 + 2 * level) / (5 * 2^15)
    // ------------------------------------------------------------------
    logic [17:0] factor;
    logic [25:0] cp_next [3];
    logic [25:0] cp_reg  [3];
    logic [15:0] lvc_reg;
    logic [25:0] recip   [3];
    logic [23:0] color_next;
    logic [23:0] color_reg;
    logic [15:0] level_out_reg;

    assign factor = LEVEL_BASE + {1'b0, level_reg, 1'b0};

    always_comb begin
        for (int n = 0; n < 3; n++) begin
            cp_next[n] = 26'(col_dly[L1+L2+3][8*n +: 8]) * 26'(factor);
            recip[n]   = 26'(cp_reg[n][25:15]) * 26'(RECIP_FIVE);
            color_next[8*n +: 8] = recip[n][23:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            cp_reg        <= cp_next;
            lvc_reg       <= level_reg;
            color_reg     <= color_next;
            level_out_reg <= lvc_reg;
        end
    end

    // ------------------------------------------------------------------
    // valid bits
    // ------------------------------------------------------------------
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata  = {level_out_reg, color_reg};

endmodule
